### rtl/drlt_pkg.sv
// Shared types and constants of the dense rank lookup table.
package drlt_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 128;
   localparam int ID_BITS_DEFAULT     = 8;
   localparam int SCORE_BITS_DEFAULT  = 8;

   localparam int FIELD_BITS    = 8;
   localparam int RANK_BITS     = 9;
   localparam int REQ_DATA_BITS = 16;
   localparam int RSP_DATA_BITS = 16;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COUNT,
      ST_REPLY
   } drlt_state_type;

endpackage

### rtl/drlt_entry_store.sv
// Entry memory: identifiers and scores, one write and one registered read port.
module drlt_entry_store #(
   parameter int MAX_ENTRIES = drlt_pkg::MAX_ENTRIES_DEFAULT,
   parameter int ID_BITS     = drlt_pkg::ID_BITS_DEFAULT,
   parameter int SCORE_BITS  = drlt_pkg::SCORE_BITS_DEFAULT,
   parameter int IDX_BITS    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [IDX_BITS-1:0]   wr_addr,
   input  logic [ID_BITS-1:0]    wr_id,
   input  logic [SCORE_BITS-1:0] wr_score,
   input  logic                  rd_en,
   input  logic [IDX_BITS-1:0]   rd_addr,
   output logic [ID_BITS-1:0]    rd_id,
   output logic [SCORE_BITS-1:0] rd_score
);

   logic [ID_BITS-1:0]    ids_mem    [MAX_ENTRIES];
   logic [SCORE_BITS-1:0] scores_mem [MAX_ENTRIES];
   logic [ID_BITS-1:0]    rd_id_ff;
   logic [SCORE_BITS-1:0] rd_score_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ids_mem[wr_addr]    <= wr_id;
         scores_mem[wr_addr] <= wr_score;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_id_ff    <= ids_mem[rd_addr];
         rd_score_ff <= scores_mem[rd_addr];
      end
   end

   assign rd_id    = rd_id_ff;
   assign rd_score = rd_score_ff;

endmodule

### rtl/drlt_score_map.sv
// Score presence map and the chunked counter of present scores above a given score.
module drlt_score_map #(
   parameter int SCORE_BITS = drlt_pkg::SCORE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  set_en,
   input  logic [SCORE_BITS-1:0] set_score,
   input  logic                  start,
   input  logic [SCORE_BITS-1:0] start_score,
   output logic                  done,
   output logic [SCORE_BITS-1:0] count
);

   localparam int CHB       = (SCORE_BITS >= 3) ? 3 : SCORE_BITS;
   localparam int CH        = 1 << CHB;
   localparam int CIDX_BITS = (SCORE_BITS > CHB) ? SCORE_BITS - CHB : 1;
   localparam int NCHUNK    = 1 << (SCORE_BITS - CHB);
   localparam int VBITS     = CIDX_BITS + CHB;

   logic [CH-1:0]         seen_ff [NCHUNK];
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CIDX_BITS-1:0]  chunk_ff, chunk_in;
   logic [SCORE_BITS-1:0] score_ff, score_in;
   logic [SCORE_BITS-1:0] count_ff, count_in;
   logic [CH-1:0]         chunk_bits;
   logic [CHB:0]          pc;
   logic [VBITS-1:0]      v;
   logic                  last_chunk;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NCHUNK; c++) begin
            seen_ff[c] <= '0;
         end
      end else if (set_en) begin
         seen_ff[CIDX_BITS'(set_score >> CHB)][set_score[CHB-1:0]] <= 1'b1;
      end
   end

   // popcount of the present scores in this chunk that lie above the query score
   always_comb begin
      chunk_bits = seen_ff[chunk_ff];
      pc         = '0;
      v          = '0;
      for (int j = 0; j < CH; j++) begin
         v = {chunk_ff, CHB'(j)};
         if (chunk_bits[j] && (v > VBITS'(score_ff))) begin
            pc = pc + (CHB+1)'(1);
         end
      end
   end

   assign last_chunk = (chunk_ff == CIDX_BITS'(NCHUNK - 1));

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      chunk_in = chunk_ff;
      score_in = score_ff;
      count_in = count_ff;
      if (start) begin
         // begin at the chunk holding the score; lower chunks cannot count
         busy_in  = 1'b1;
         chunk_in = CIDX_BITS'(start_score >> CHB);
         score_in = start_score;
         count_in = '0;
      end else if (busy_ff) begin
         count_in = count_ff + SCORE_BITS'(pc);
         if (last_chunk) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            chunk_in = chunk_ff + CIDX_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      chunk_ff <= chunk_in;
      score_ff <= score_in;
      count_ff <= count_in;
   end

   assign done  = done_ff;
   assign count = count_ff;

endmodule

### rtl/dense_rank_lookup_table.sv
// Top level of the dense rank lookup table: request sequencer and result register.
//
// Request channel req_*: req_tuser selects the function (0 load, 1 query),
// req_tdata carries the identifier and the score. A load gives no item back; a
// load into a full table is dropped. A query walks the stored entries one per
// cycle through the entry memory read port (registered read), then the presence
// map counts present scores above the matching score, eight score values per
// cycle. A query keeps req_tready low while it runs, and its item shows on
// rsp_tvalid as req_tready returns; with no match it ends and gives no item.
// Result channel rsp_*: rsp_tdata carries the rank. The result register holds
// an item until it is taken; loads and a new query are accepted meanwhile, and a
// later query waits at its end for the register to free. Reset empties the table
// and clears the presence map in the same cycle.
module dense_rank_lookup_table #(
   parameter int MAX_ENTRIES = drlt_pkg::MAX_ENTRIES_DEFAULT,
   parameter int ID_BITS     = drlt_pkg::ID_BITS_DEFAULT,
   parameter int SCORE_BITS  = drlt_pkg::SCORE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [drlt_pkg::REQ_DATA_BITS-1:0] req_tdata,  // team_id[7:0], score[15:8]
   input  logic                               req_tuser,  // func[0]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [drlt_pkg::RSP_DATA_BITS-1:0] rsp_tdata   // rank[8:0], zeros[15:9]
);

   import drlt_pkg::*;

   localparam int IDX_BITS = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_BITS = $clog2(MAX_ENTRIES + 1);

   drlt_state_type        state_ff, state_in;
   logic [CNT_BITS-1:0]   entry_count_ff, entry_count_in;
   logic [CNT_BITS-1:0]   issue_ff, issue_in;
   logic                  pend_ff, pend_in;
   logic [ID_BITS-1:0]    qid_ff, qid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RANK_BITS-1:0]  rank_ff, rank_in;

   logic                  req_accept;
   logic [FIELD_BITS-1:0] req_team_id;
   logic [FIELD_BITS-1:0] req_score;
   logic [ID_BITS-1:0]    in_id;
   logic [SCORE_BITS-1:0] in_score;
   logic                  table_full;

   logic                  wr_en;
   logic                  rd_en;
   logic [ID_BITS-1:0]    rd_id;
   logic [SCORE_BITS-1:0] rd_score;
   logic                  map_start;
   logic                  map_done;
   logic [SCORE_BITS-1:0] map_count;
   logic [SCORE_BITS:0]   rank_full;

   assign req_team_id = req_tdata[FIELD_BITS-1:0];
   assign req_score   = req_tdata[2*FIELD_BITS-1:FIELD_BITS];
   assign in_id       = ID_BITS'(req_team_id);
   assign in_score    = SCORE_BITS'(req_score);
   assign table_full  = (entry_count_ff == CNT_BITS'(MAX_ENTRIES));
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign wr_en       = req_accept && (req_tuser == FUNC_LOAD) && !table_full;
   assign rank_full   = {1'b0, map_count} + (SCORE_BITS+1)'(1);

   drlt_entry_store #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .ID_BITS     (ID_BITS),
      .SCORE_BITS  (SCORE_BITS),
      .IDX_BITS    (IDX_BITS)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (entry_count_ff[IDX_BITS-1:0]),
      .wr_id    (in_id),
      .wr_score (in_score),
      .rd_en    (rd_en),
      .rd_addr  (issue_ff[IDX_BITS-1:0]),
      .rd_id    (rd_id),
      .rd_score (rd_score)
   );

   drlt_score_map #(
      .SCORE_BITS (SCORE_BITS)
   ) u_map (
      .clock       (clock),
      .reset       (reset),
      .set_en      (wr_en),
      .set_score   (in_score),
      .start       (map_start),
      .start_score (rd_score),
      .done        (map_done),
      .count       (map_count)
   );

   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      issue_in       = issue_ff;
      pend_in        = 1'b0;
      qid_in         = qid_ff;
      rsp_valid_in   = rsp_valid_ff;
      rank_in        = rank_ff;
      rd_en          = 1'b0;
      map_start      = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == FUNC_LOAD) begin
                  if (!table_full) begin
                     entry_count_in = entry_count_ff + CNT_BITS'(1);
                  end
               end else begin
                  qid_in   = in_id;
                  issue_in = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // issue one read per cycle, compare the entry read the cycle before
            rd_en   = (issue_ff < entry_count_ff);
            pend_in = rd_en;
            if (rd_en) begin
               issue_in = issue_ff + CNT_BITS'(1);
            end
            if (pend_ff && (rd_id == qid_ff)) begin
               map_start = 1'b1;
               state_in  = ST_COUNT;
            end else if (!pend_ff && !rd_en) begin
               // every entry compared, no match: drop the query
               state_in = ST_IDLE;
            end
         end
         ST_COUNT: begin
            if (map_done) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rank_in      = RANK_BITS'(rank_full);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff <= issue_in;
      qid_ff   <= qid_in;
      rank_ff  <= rank_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rank_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CNT_BITS'(MAX_ENTRIES))
      else $error("entry count beyond table depth");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_tuser == FUNC_LOAD) && table_full) |=> table_full)
      else $error("load into full table changed the entry count");

   a_done_in_count: assert property (@(posedge clock) disable iff (reset)
      map_done |-> (state_ff == ST_COUNT))
      else $error("score count finished outside a query");

   a_reply_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPLY) |->
         ($past(state_ff) == ST_COUNT || $past(state_ff) == ST_REPLY))
      else $error("reply reached without a finished count");

endmodule

### test/dense_rank_lookup_table_test.sv
// Self-checking testbench of the dense rank lookup table: load and query items with rank prediction.
module dense_rank_lookup_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   import drlt_pkg::*;

   localparam int SCORE_VALUES = 1 << SCORE_BITS_DEFAULT;
   localparam int QUIET_LIMIT  = 20000;
   localparam int HOLD_CYCLES  = 600;
   localparam int TAIL_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 1900;

   class rank_scoreboard;
      logic [FIELD_BITS-1:0] entry_ids[$];
      logic [FIELD_BITS-1:0] entry_scores[$];
      bit                    score_seen[SCORE_VALUES];
      logic [RANK_BITS-1:0]  expected_ranks[$];
      int unsigned           errors;

      function void report(string what);
         errors++;
         if (errors <= 10) $display("%0t: %s", $realtime, what);
      endfunction

      function int pending();
         return expected_ranks.size();
      endfunction

      function void note_request(logic func, logic [FIELD_BITS-1:0] id,
                                 logic [FIELD_BITS-1:0] score);
         int unsigned above;
         if (func == FUNC_LOAD) begin
            // drop loads into a full table
            if (entry_ids.size() < MAX_ENTRIES_DEFAULT) begin
               entry_ids.insert(entry_ids.size(), id);
               entry_scores.insert(entry_scores.size(), score);
               score_seen[score] = 1'b1;
            end
            return;
         end
         // earliest stored entry with this identifier answers
         foreach (entry_ids[i]) begin
            if (entry_ids[i] == id) begin
               above = 0;
               for (int v = int'(entry_scores[i]) + 1; v < SCORE_VALUES; v++)
                  above += score_seen[v];
               expected_ranks.insert(expected_ranks.size(), RANK_BITS'(above + 1));
               return;
            end
         end
      endfunction

      function void check_rank(logic [RSP_DATA_BITS-1:0] data);
         logic [RSP_DATA_BITS-1:0] want;
         if (expected_ranks.size() == 0) begin
            report($sformatf("rank item 0x%04h with none expected", data));
            return;
         end
         want = RSP_DATA_BITS'(expected_ranks.pop_front());
         if (data !== want)
            report($sformatf("rank mismatch: expected 0x%04h actual 0x%04h", want, data));
      endfunction
   endclass

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;  // team_id[7:0], score[15:8]
   logic                     req_tuser  = FUNC_LOAD;  // func[0]
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;  // rank[8:0], zeros[15:9]

   rank_scoreboard        ranks = new();
   bit                    steady      = 1'b0;
   bit                    hold_off_go = 1'b0;
   int unsigned           quiet_cycles = 0;
   int unsigned           loaded = 0;
   logic [FIELD_BITS-1:0] known_ids[$];

   dense_rank_lookup_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            ranks.note_request(req_tuser, req_tdata[7:0], req_tdata[15:8]);
         if (rsp_tvalid && rsp_tready)
            ranks.check_rank(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_go) begin
            hold_off_go = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= steady || ($urandom_range(99) >= 35);
         @(posedge clock);
      end
   end

   task automatic send_item(logic func, logic [FIELD_BITS-1:0] id,
                            logic [FIELD_BITS-1:0] score);
      if (!steady && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 35);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {score, id};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic load_entry(logic [FIELD_BITS-1:0] id, logic [FIELD_BITS-1:0] score);
      send_item(FUNC_LOAD, id, score);
      if (loaded < MAX_ENTRIES_DEFAULT) begin
         known_ids.insert(known_ids.size(), id);
         loaded++;
      end
   endtask

   task automatic query_id(logic [FIELD_BITS-1:0] id);
      // score is ignored on a query; toggle it anyway
      send_item(FUNC_QUERY, id, FIELD_BITS'($urandom_range(255)));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (ranks.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned           useful;
      int unsigned           n;
      bit                    do_load;
      logic [FIELD_BITS-1:0] score;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // query on an empty table, extremes, a duplicate identifier, a miss
      query_id(8'd5);
      load_entry(8'd0, 8'd0);
      load_entry(8'd255, 8'd255);
      load_entry(8'h80, 8'h80);
      query_id(8'd0);
      query_id(8'd255);
      query_id(8'h80);
      load_entry(8'd255, 8'd10);
      query_id(8'd255);
      query_id(8'd77);
      load_entry(8'h55, 8'hAA);
      load_entry(8'hAA, 8'h55);
      load_entry(8'h01, 8'h80);
      query_id(8'hAA);
      query_id(8'h55);
      query_id(8'h01);
      query_id(8'd0);
      drain();

      useful = 0;
      n = 0;
      while (useful < RANDOM_ITEMS) begin
         n++;
         steady = (n >= 700 && n < 950);
         if (n == 300) hold_off_go = 1'b1;
         if (n == 1200) drain();
         if (loaded < MAX_ENTRIES_DEFAULT) do_load = 1'($urandom_range(1));
         else do_load = ($urandom_range(9) == 0);
         if (do_load) begin
            case ($urandom_range(3))
               0: score = FIELD_BITS'($urandom_range(7));
               1: score = FIELD_BITS'(255 - $urandom_range(7));
               default: score = FIELD_BITS'($urandom_range(255));
            endcase
            // loads into a full table are ignored and do not count
            if (loaded < MAX_ENTRIES_DEFAULT) useful++;
            load_entry(FIELD_BITS'($urandom_range(255)), score);
         end else begin
            useful++;
            if (known_ids.size() > 0 && $urandom_range(99) < 85)
               query_id(known_ids[$urandom_range(known_ids.size() - 1)]);
            else
               query_id(FIELD_BITS'($urandom_range(255)));
         end
      end

      drain();
      steady = 1'b0;
      // let a trailing query with no match run out
      repeat (TAIL_CYCLES) @(posedge clock);
      if (ranks.pending() != 0)
         ranks.report($sformatf("%0d rank items never arrived", ranks.pending()));
      if (ranks.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### files.f
rtl/drlt_pkg.sv
rtl/drlt_entry_store.sv
rtl/drlt_score_map.sv
rtl/dense_rank_lookup_table.sv
test/dense_rank_lookup_table_test.sv
